### rtl/sebd_pkg.sv
package sebd_pkg;

    localparam int VALUE_W   = 16;
    localparam int MAX_BINS  = 1024;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int DIVISOR_W = BIN_W + 1;
    localparam int ACC_W     = VALUE_W + BIN_W;
    localparam int QCNT_W    = $clog2(ACC_W);

    localparam int HIST_AW       = 6;
    localparam int HISTORY_DEPTH = 1 << HIST_AW;
    localparam int FILL_W        = HIST_AW + 1;

    localparam int SUM_W   = VALUE_W + HIST_AW;
    localparam int SQ_W    = 2 * VALUE_W + HIST_AW;
    localparam int NUM_W   = 2 * SUM_W;
    localparam int VAR_W   = 2 * VALUE_W;
    localparam int GAIN_W  = 16;
    localparam int GAIN_FRAC = 12;
    localparam int GV_W    = GAIN_W + VAR_W;
    localparam int THR_W   = GV_W + 1;
    localparam int THR_FRAC = GAIN_FRAC + VAR_W;
    localparam int PROD_W  = THR_W + VALUE_W;

    localparam int IN_W       = VALUE_W + BIN_W;
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W      = 2 + VALUE_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 32;

    localparam logic [CFG_IW-1:0] CFG_BAND_LOW  = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_BAND_HIGH = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_VAR_GAIN  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_THR_OFFSET = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MIN_VAR   = 3'd4;

    localparam logic [BIN_W-1:0]  BAND_LOW_RST    = 10'd0;
    localparam logic [BIN_W-1:0]  BAND_HIGH_RST   = 10'd512;
    localparam logic [GAIN_W-1:0] VAR_GAIN_RST    = 16'd5120;
    localparam logic [GAIN_W-1:0] THR_OFFSET_RST  = 16'd6554;
    localparam logic [VAR_W-1:0]  MIN_VAR_RST     = 32'd21475;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQUARE,
        ST_UPDATE,
        ST_SUM_SQ,
        ST_VARIANCE,
        ST_THRESH,
        ST_BOUND,
        ST_EMIT
    } state_t;

endpackage

### rtl/spectral_energy_beat_detector.sv
// Spectral energy beat detector. Bins stream in on s_axis at one per cycle; bins whose
// index lies in [band_low_bin, band_high_bin] are summed into a saturating accumulator.
// The bin marked tlast closes the frame: its sum is handed to a bit-serial restoring
// divider (one quotient bit per cycle) that yields the band energy, followed by a
// read-modify-write of the 64-entry energy history memory and running window sums, and,
// once the window is full, mean/variance/threshold arithmetic in the sum-square,
// variance, threshold and bound steps. Bins of the next frame keep flowing during that
// time; only the next tlast bin is held off until the previous frame's result has been
// placed in the output register. The first 64 frames report warming_up with no beat.
module spectral_energy_beat_detector
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bin_value [15:0], bin_index [25:16], zero pad
    input  logic [sebd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // beat [0], warming_up [1], frame_energy [17:2], zero pad
    output logic [sebd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [sebd_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [sebd_pkg::CFG_DW-1:0]         cfg_data
);

    sebd_pkg::state_t state_reg, state_next;

    logic [sebd_pkg::BIN_W-1:0]   band_low_reg, band_high_reg;
    logic [sebd_pkg::GAIN_W-1:0]  gain_reg, offset_reg;
    logic [sebd_pkg::VAR_W-1:0]   min_var_reg;

    logic [sebd_pkg::VALUE_W-1:0] in_value;
    logic [sebd_pkg::BIN_W-1:0]   in_index;
    logic                         in_fire, in_band, band_empty;
    logic [sebd_pkg::ACC_W:0]     acc_sum;
    logic [sebd_pkg::ACC_W-1:0]   acc_reg, acc_add, acc_upd;

    logic [sebd_pkg::ACC_W-1:0]     quot_reg;
    logic [sebd_pkg::BIN_W:0]       rem_reg;
    logic [sebd_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [sebd_pkg::QCNT_W-1:0]    cnt_reg;
    logic [sebd_pkg::DIVISOR_W:0]   trial;
    logic                           trial_ge;
    logic                           div_last;

    logic [sebd_pkg::VALUE_W-1:0]   hist_mem [sebd_pkg::HISTORY_DEPTH];
    logic [sebd_pkg::VALUE_W-1:0]   rd_data_reg;
    logic [sebd_pkg::HIST_AW-1:0]   head_reg;
    logic [sebd_pkg::FILL_W-1:0]    fill_reg;
    logic                           full;

    logic [sebd_pkg::VALUE_W-1:0]   energy_c, old_c;
    logic [sebd_pkg::VALUE_W-1:0]   energy_reg, old_reg;
    logic [2*sebd_pkg::VALUE_W-1:0] e_sq_reg, o_sq_reg;
    logic [sebd_pkg::SUM_W-1:0]     sum_reg;
    logic [sebd_pkg::SQ_W-1:0]      sum_sq_reg;
    logic [sebd_pkg::NUM_W-1:0]     sum2_reg, num_c;
    logic [sebd_pkg::VAR_W-1:0]     var_reg;
    logic [sebd_pkg::VALUE_W-1:0]   mean_reg;
    logic [sebd_pkg::GV_W-1:0]      gv_c;
    logic [sebd_pkg::THR_W-1:0]     thr_reg;
    logic [sebd_pkg::PROD_W-1:0]    prod_reg, energy_scaled;
    logic                           warm_reg, beat_c;

    logic div_start, div_step, sq_en, upd_en, sum2_en, var_en, thr_en, bnd_en, out_load;
    logic out_free;

    assign in_value = s_axis_tdata[sebd_pkg::VALUE_W-1:0];
    assign in_index = s_axis_tdata[sebd_pkg::IN_W-1:sebd_pkg::VALUE_W];
    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign in_band  = (in_index >= band_low_reg) && (in_index <= band_high_reg);
    assign band_empty = band_low_reg > band_high_reg;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign full     = fill_reg[sebd_pkg::HIST_AW];

    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + (sebd_pkg::ACC_W + 1)'(in_value);
        acc_add = acc_sum[sebd_pkg::ACC_W] ? '1 : acc_sum[sebd_pkg::ACC_W-1:0];
        acc_upd = in_band ? acc_add : acc_reg;
    end

    always_comb
    begin
        trial    = {rem_reg, quot_reg[sebd_pkg::ACC_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
        div_last = cnt_reg == sebd_pkg::QCNT_W'(sebd_pkg::ACC_W - 1);
    end

    always_comb
    begin
        energy_c = (|quot_reg[sebd_pkg::ACC_W-1:sebd_pkg::VALUE_W]) ? '1
                   : quot_reg[sebd_pkg::VALUE_W-1:0];
        old_c    = full ? rd_data_reg : '0;
        num_c    = {sum_sq_reg, {sebd_pkg::HIST_AW{1'b0}}} - sum2_reg;
        gv_c     = sebd_pkg::GV_W'(gain_reg) * sebd_pkg::GV_W'(var_reg);
        energy_scaled = sebd_pkg::PROD_W'({energy_reg, {sebd_pkg::THR_FRAC{1'b0}}});
        beat_c   = !warm_reg && (energy_scaled > prod_reg) && (var_reg > min_var_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sebd_pkg::ST_IDLE:
                if (in_fire && s_axis_tlast) state_next = sebd_pkg::ST_DIV;
            sebd_pkg::ST_DIV:
                if (div_last) state_next = sebd_pkg::ST_SQUARE;
            sebd_pkg::ST_SQUARE:
                state_next = sebd_pkg::ST_UPDATE;
            sebd_pkg::ST_UPDATE:
                state_next = full ? sebd_pkg::ST_SUM_SQ : sebd_pkg::ST_EMIT;
            sebd_pkg::ST_SUM_SQ:
                state_next = sebd_pkg::ST_VARIANCE;
            sebd_pkg::ST_VARIANCE:
                state_next = sebd_pkg::ST_THRESH;
            sebd_pkg::ST_THRESH:
                state_next = sebd_pkg::ST_BOUND;
            sebd_pkg::ST_BOUND:
                state_next = sebd_pkg::ST_EMIT;
            sebd_pkg::ST_EMIT:
                if (out_free) state_next = sebd_pkg::ST_IDLE;
            default:
                state_next = sebd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == sebd_pkg::ST_IDLE) || !s_axis_tlast;
        div_start = (state_reg == sebd_pkg::ST_IDLE) && in_fire && s_axis_tlast;
        div_step  = state_reg == sebd_pkg::ST_DIV;
        sq_en     = state_reg == sebd_pkg::ST_SQUARE;
        upd_en    = state_reg == sebd_pkg::ST_UPDATE;
        sum2_en   = state_reg == sebd_pkg::ST_SUM_SQ;
        var_en    = state_reg == sebd_pkg::ST_VARIANCE;
        thr_en    = state_reg == sebd_pkg::ST_THRESH;
        bnd_en    = state_reg == sebd_pkg::ST_BOUND;
        out_load  = (state_reg == sebd_pkg::ST_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sebd_pkg::ST_IDLE;
            band_low_reg  <= sebd_pkg::BAND_LOW_RST;
            band_high_reg <= sebd_pkg::BAND_HIGH_RST;
            gain_reg      <= sebd_pkg::VAR_GAIN_RST;
            offset_reg    <= sebd_pkg::THR_OFFSET_RST;
            min_var_reg   <= sebd_pkg::MIN_VAR_RST;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sum_sq_reg    <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    sebd_pkg::CFG_BAND_LOW:   band_low_reg  <= cfg_data[sebd_pkg::BIN_W-1:0];
                    sebd_pkg::CFG_BAND_HIGH:  band_high_reg <= cfg_data[sebd_pkg::BIN_W-1:0];
                    sebd_pkg::CFG_VAR_GAIN:   gain_reg      <= cfg_data[sebd_pkg::GAIN_W-1:0];
                    sebd_pkg::CFG_THR_OFFSET: offset_reg    <= cfg_data[sebd_pkg::GAIN_W-1:0];
                    sebd_pkg::CFG_MIN_VAR:    min_var_reg   <= cfg_data[sebd_pkg::VAR_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire)
                acc_reg <= s_axis_tlast ? '0 : acc_upd;
            if (div_start)
                cnt_reg <= '0;
            else if (div_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (upd_en)
            begin
                head_reg   <= head_reg + 1'b1;
                if (!full)
                    fill_reg <= fill_reg + 1'b1;
                sum_reg    <= sum_reg + sebd_pkg::SUM_W'(energy_reg)
                              - sebd_pkg::SUM_W'(old_reg);
                sum_sq_reg <= sum_sq_reg + sebd_pkg::SQ_W'(e_sq_reg)
                              - sebd_pkg::SQ_W'(o_sq_reg);
            end
            if (out_load)
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tready)
                m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            quot_reg    <= band_empty ? '0 : acc_upd;
            rem_reg     <= '0;
            divisor_reg <= band_empty ? sebd_pkg::DIVISOR_W'(1)
                           : sebd_pkg::DIVISOR_W'(band_high_reg)
                             - sebd_pkg::DIVISOR_W'(band_low_reg)
                             + sebd_pkg::DIVISOR_W'(1);
        end
        else if (div_step)
        begin
            quot_reg <= {quot_reg[sebd_pkg::ACC_W-2:0], trial_ge};
            rem_reg  <= trial_ge ? sebd_pkg::DIVISOR_W'(trial - {1'b0, divisor_reg})
                        : sebd_pkg::DIVISOR_W'(trial);
        end
        if (sq_en)
        begin
            energy_reg <= energy_c;
            old_reg    <= old_c;
            e_sq_reg   <= (2*sebd_pkg::VALUE_W)'(energy_c) * (2*sebd_pkg::VALUE_W)'(energy_c);
            o_sq_reg   <= (2*sebd_pkg::VALUE_W)'(old_c) * (2*sebd_pkg::VALUE_W)'(old_c);
        end
        if (upd_en)
            warm_reg <= !full;
        if (sum2_en)
            sum2_reg <= sebd_pkg::NUM_W'(sum_reg) * sebd_pkg::NUM_W'(sum_reg);
        if (var_en)
        begin
            var_reg  <= num_c[sebd_pkg::NUM_W-1:2*sebd_pkg::HIST_AW];
            mean_reg <= sum_reg[sebd_pkg::SUM_W-1:sebd_pkg::HIST_AW];
        end
        if (thr_en)
            thr_reg <= {1'b0, gv_c} + sebd_pkg::THR_W'({offset_reg, {sebd_pkg::VAR_W{1'b0}}});
        if (bnd_en)
            prod_reg <= sebd_pkg::PROD_W'(thr_reg) * sebd_pkg::PROD_W'(mean_reg);
        if (out_load)
            m_axis_tdata <= sebd_pkg::OUT_TDATA_W'({energy_reg, warm_reg, beat_c});
    end

    always_ff @(posedge clk)
    begin
        if (upd_en)
            hist_mem[head_reg] <= energy_reg;
        rd_data_reg <= hist_mem[head_reg];
    end

endmodule
